@@ rtl/tte_pkg.sv @@
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants of the transposition table engine: command
// codes, the classified item passed from the front to the back, the table
// entry layout, the result item and the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

	// Default table size: 2**INDEX_BITS_DEF entries.
	localparam int INDEX_BITS_DEF = 12;

	// Depth of the queue between front and back (power of two).
	localparam int QUEUE_DEPTH = 2;

	// Field widths.
	localparam int KEY_W   = 64;
	localparam int SCORE_W = 32;
	localparam int DEPTH_W = 16;
	localparam int BOUND_W = 8;
	localparam int AGE_W   = 8;
	localparam int MOVE_W  = 32;
	localparam int FILL_W  = 13;
	localparam int CMD_W   = 2;

	// Stream widths.
	localparam int IN_DATA_W  = 152;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 120;
	localparam int OUT_USER_W = 2;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_STORE = 2'd0,
		CMD_PROBE = 2'd1,
		CMD_AGE   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Classified item held in the front stage and the queue.
	typedef struct packed {
		cmd_t                 cmd;
		logic [KEY_W-1:0]     key;
		logic [SCORE_W-1:0]   score;
		logic [DEPTH_W-1:0]   depth;
		logic [BOUND_W-1:0]   bound;
		logic [MOVE_W-1:0]    move;
	} op_t;

	// One table entry; an all-zero entry is an empty one.
	typedef struct packed {
		logic [MOVE_W-1:0]    move;
		logic [AGE_W-1:0]     age;
		logic [BOUND_W-1:0]   bound;
		logic [DEPTH_W-1:0]   depth;
		logic [SCORE_W-1:0]   score;
		logic [KEY_W-1:0]     key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Result item.
	typedef struct packed {
		logic                 hit;
		logic                 written;
		logic [SCORE_W-1:0]   score;
		logic [DEPTH_W-1:0]   depth;
		logic [BOUND_W-1:0]   bound;
		logic [AGE_W-1:0]     age;
		logic [MOVE_W-1:0]    move;
		logic [FILL_W-1:0]    filled;
		logic [AGE_W-1:0]     search_age;
	} res_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

endpackage

`default_nettype wire

@@ rtl/tte_front.sv @@
// ----------------------------------------------------------------------------
// tte_front
// Input side: accepts items from the stream, decodes the command and holds
// the classified item in one register until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [tte_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic [tte_pkg::IN_USER_W-1:0] s_tuser,
	output logic                               push,
	output tte_pkg::op_t                       push_op,
	input  wire logic                          q_ready
);

	logic          vld_s1;
	tte_pkg::op_t  op_s1;
	tte_pkg::op_t  op_dec;
	logic          load;

	// Decode the incoming item
	always_comb begin
		op_dec     = '0;
		op_dec.cmd = tte_pkg::cmd_t'(s_tuser[tte_pkg::CMD_W-1:0]);
		unique case (op_dec.cmd)
			tte_pkg::CMD_STORE: begin
				op_dec.key   = s_tdata[63:0];
				op_dec.score = s_tdata[95:64];
				op_dec.depth = s_tdata[111:96];
				op_dec.bound = s_tdata[119:112];
				op_dec.move  = s_tdata[151:120];
			end
			tte_pkg::CMD_PROBE: begin
				op_dec.key = s_tdata[63:0];
			end
			tte_pkg::CMD_AGE,
			tte_pkg::CMD_CLEAR: begin
				op_dec.key = '0;
			end
			default: begin
				op_dec.key = '0;
			end
		endcase
	end

	assign push     = vld_s1 && q_ready;
	assign s_tready = !vld_s1 || q_ready;
	assign load     = s_tvalid && s_tready;
	assign push_op  = op_s1;

	// Hold the item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1 <= op_dec;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tte_queue.sv @@
// ----------------------------------------------------------------------------
// tte_queue
// Short first-in first-out queue of classified items between the front and
// the back, so that either side can stall without stopping the other.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire tte_pkg::op_t push_op,
	output logic              q_ready,
	input  wire logic         pop,
	output logic              q_valid,
	output tte_pkg::op_t      head
);

	localparam int PTR_W = (tte_pkg::QUEUE_DEPTH > 1) ? $clog2(tte_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(tte_pkg::QUEUE_DEPTH + 1);

	tte_pkg::op_t     slot_q [tte_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_ready = (cnt_q != CNT_W'(tte_pkg::QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = slot_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tte_back.sv @@
// ----------------------------------------------------------------------------
// tte_back
// Execution side: owns the entry memory, the search age and the occupancy
// count. Reads the addressed entry, applies the replacement rule, writes
// back and loads the result register. Sweeps the memory to zero after reset
// and on a clear command.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_back #(
	parameter int INDEX_BITS = tte_pkg::INDEX_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  wire tte_pkg::op_t head,
	output logic              pop,
	output logic              res_valid,
	output tte_pkg::res_t     res,
	input  wire logic         res_ready
);

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int OCC_W = INDEX_BITS + 1;

	// Entry memory, no reset: the sweep zeroes it
	logic [tte_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [tte_pkg::ENTRY_W-1:0] rd_entry_s1;

	tte_pkg::bk_state_t     state_q, state_d;
	logic [INDEX_BITS-1:0]  sweep_q, sweep_d;
	logic [tte_pkg::AGE_W-1:0] age_q, age_d;
	logic [OCC_W-1:0]       occ_q, occ_d;
	tte_pkg::op_t           op_q;
	logic                   op_load;
	logic                   out_valid_q;
	tte_pkg::res_t          out_q, res_d;
	logic                   res_load;

	logic                   mem_we;
	logic [INDEX_BITS-1:0]  mem_wa;
	logic [tte_pkg::ENTRY_W-1:0] mem_wd;
	logic [INDEX_BITS-1:0]  mem_ra;

	tte_pkg::entry_t        cur;
	tte_pkg::entry_t        new_entry;
	logic                   out_free;
	logic                   replace;
	logic                   key_match;

	assign mem_ra    = head.key[INDEX_BITS-1:0];
	assign cur       = tte_pkg::entry_t'(rd_entry_s1);
	assign out_free  = !out_valid_q || res_ready;
	assign key_match = (cur.key == op_q.key);
	assign replace   = (cur.key == '0) || key_match || (cur.age != age_q) ||
	                   ($signed(op_q.depth) >= $signed(cur.depth));

	always_comb begin
		new_entry       = '0;
		new_entry.key   = op_q.key;
		new_entry.score = op_q.score;
		new_entry.depth = op_q.depth;
		new_entry.bound = op_q.bound;
		new_entry.age   = age_q;
		new_entry.move  = op_q.move;
	end

	// Sequence the sweep, dispatch and execution
	always_comb begin
		state_d  = state_q;
		sweep_d  = sweep_q;
		age_d    = age_q;
		occ_d    = occ_q;
		pop      = 1'b0;
		op_load  = 1'b0;
		res_load = 1'b0;
		res_d    = '0;
		mem_we   = 1'b0;
		mem_wa   = sweep_q;
		mem_wd   = '0;
		unique case (state_q)
			tte_pkg::BK_CLEAR: begin
				mem_we  = 1'b1;
				sweep_d = sweep_q + INDEX_BITS'(1);
				if (sweep_q == {INDEX_BITS{1'b1}}) begin
					state_d = tte_pkg::BK_IDLE;
				end
			end
			tte_pkg::BK_IDLE: begin
				if (q_valid && out_free) begin
					pop = 1'b1;
					unique case (head.cmd)
						tte_pkg::CMD_STORE,
						tte_pkg::CMD_PROBE: begin
							op_load = 1'b1;
							state_d = tte_pkg::BK_EXEC;
						end
						tte_pkg::CMD_AGE: begin
							age_d    = age_q + tte_pkg::AGE_W'(1);
							res_load = 1'b1;
						end
						tte_pkg::CMD_CLEAR: begin
							occ_d    = '0;
							sweep_d  = '0;
							res_load = 1'b1;
							state_d  = tte_pkg::BK_CLEAR;
						end
						default: begin
							res_load = 1'b0;
						end
					endcase
				end
			end
			tte_pkg::BK_EXEC: begin
				res_load = 1'b1;
				state_d  = tte_pkg::BK_IDLE;
				if (op_q.cmd == tte_pkg::CMD_STORE) begin
					if (replace) begin
						mem_we        = 1'b1;
						mem_wa        = op_q.key[INDEX_BITS-1:0];
						mem_wd        = new_entry;
						res_d.written = 1'b1;
						if (cur.key == '0 && op_q.key != '0) begin
							occ_d = occ_q + OCC_W'(1);
						end else if (cur.key != '0 && op_q.key == '0) begin
							occ_d = occ_q - OCC_W'(1);
						end
					end
				end else if (key_match) begin
					res_d.hit   = 1'b1;
					res_d.score = cur.score;
					res_d.depth = cur.depth;
					res_d.bound = cur.bound;
					res_d.age   = cur.age;
					res_d.move  = cur.move;
				end
			end
			default: begin
				state_d = tte_pkg::BK_CLEAR;
			end
		endcase
		res_d.filled     = tte_pkg::FILL_W'(occ_d);
		res_d.search_age = age_d;
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tte_pkg::BK_CLEAR;
			sweep_q     <= '0;
			age_q       <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			age_q   <= age_d;
			occ_q   <= occ_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the dispatched item and the result
	always_ff @(posedge clk) begin
		if (op_load) begin
			op_q <= head;
		end
		if (res_load) begin
			out_q <= res_d;
		end
	end

	// Memory write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Memory read port, registered
	always_ff @(posedge clk) begin
		rd_entry_s1 <= mem[mem_ra];
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

`default_nettype wire

@@ rtl/transposition_table_engine.sv @@
// ----------------------------------------------------------------------------
// transposition_table_engine
// Direct-mapped search result table with depth and age replacement.
//
// Items enter on the s_ stream: tuser carries the command (store, probe,
// new search, clear), tdata the key and the values to store. Each item gives
// exactly one result on the m_ stream: hit and written flags in tuser, the
// found entry fields, filled count and search age in tdata.
// An item passes a front register and a two-item queue, then the back end
// runs it. Store and probe first read the entry memory through a register,
// then decide and, for a store, write back; the back end takes no further
// item until that step is done. A new-search item loads its result as soon
// as the back end takes it.
// A clear item returns its result at once, then the back end sweeps all
// 2**INDEX_BITS entries to zero, one per cycle (4096 entries by default),
// and starts no further item until the sweep ends; the queue still fills.
// After reset the same sweep runs first; search age and count start at zero.
// A stalled m_tready holds the result; the queue keeps taking items until
// it and the front register are full, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module transposition_table_engine #(
	parameter int INDEX_BITS = tte_pkg::INDEX_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// key[63:0], new_score[95:64], new_depth[111:96], new_bound[119:112],
	// new_move[151:120]
	input  wire logic [tte_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  wire logic [tte_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// found_score[31:0], found_depth[47:32], found_bound[55:48],
	// found_age[63:56], found_move[95:64], filled_count[108:96],
	// search_age[116:109], zero[119:117]
	output logic [tte_pkg::OUT_DATA_W-1:0]      m_tdata,
	// hit[0], written[1]
	output logic [tte_pkg::OUT_USER_W-1:0]      m_tuser
);

	logic          push;
	tte_pkg::op_t  push_op;
	logic          q_ready;
	logic          q_valid;
	logic          pop;
	tte_pkg::op_t  head;
	tte_pkg::res_t res;

	tte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_op  (push_op),
		.q_ready  (q_ready)
	);

	tte_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.q_ready (q_ready),
		.pop     (pop),
		.q_valid (q_valid),
		.head    (head)
	);

	tte_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	// Pack the result item
	assign m_tdata = {3'b000, res.search_age, res.filled, res.move, res.age,
	                  res.bound, res.depth, res.score};
	assign m_tuser = {res.written, res.hit};

endmodule

`default_nettype wire

@@ tb/sv/transposition_table_engine_tb.sv @@
// ----------------------------------------------------------------------------
// transposition_table_engine_tb
// Self-checking bench for the transposition table engine. Each command item
// is pushed through a table model of its own as it is accepted; the single
// result item is checked field by field against that prediction. Directed
// tests cover field extremes, the replacement rule, zero keys, age wrap and
// clear, then random traffic on a few hot entries runs under three idling
// regimes on the input and output streams.
// ----------------------------------------------------------------------------
module transposition_table_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tte_pkg::*;

	localparam int INDEX_BITS     = INDEX_BITS_DEF;
	localparam int HIGH_W         = KEY_W - INDEX_BITS;
	localparam int TABLE_ENTRIES  = 1 << INDEX_BITS;
	localparam int HALF_PERIOD_NS = 6;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RANDOM_ITEMS   = 290;
	localparam int RECENT_KEEP    = 32;
	localparam logic [KEY_W-INDEX_BITS-1:0] HIGH_SPREAD = 52'h9E377_9B97_F4A7;

	// One command item as sent on the input stream
	typedef struct {
		cmd_t               cmd;
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0] depth;
		logic [BOUND_W-1:0] bound;
		logic [MOVE_W-1:0]  move;
	} table_item_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [IN_USER_W-1:0]  s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	// Table model state
	entry_t                table_mem [TABLE_ENTRIES];
	bit                    table_valid [TABLE_ENTRIES];
	logic [AGE_W-1:0]      model_age  = '0;
	int unsigned           model_fill = 0;

	res_t                  pending_results [$];
	logic [KEY_W-1:0]      recent_keys [$];

	int unsigned           send_idle_pct = 0;
	int unsigned           recv_idle_pct = 0;
	int unsigned           error_count   = 0;
	int unsigned           items_sent    = 0;
	int unsigned           results_seen  = 0;
	int unsigned           hits_seen     = 0;
	int unsigned           writes_seen   = 0;
	int unsigned           clears_sent   = 0;
	int unsigned           ages_sent     = 0;
	int unsigned           stall_cycles  = 0;

	transposition_table_engine #(
		.INDEX_BITS(INDEX_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #(HALF_PERIOD_NS) clk = ~clk;

	// Apply one item to the table model and return the result it should give
	function automatic res_t apply_table_item(input table_item_t it);
		entry_t      cur;
		entry_t      fresh;
		int unsigned idx;
		logic        replace;
		res_t        r;
		r   = '0;
		idx = 32'(it.key[INDEX_BITS-1:0]);
		cur = table_valid[idx] ? table_mem[idx] : '0;
		case (it.cmd)
			CMD_STORE: begin
				replace = (cur.key == '0) || (cur.key == it.key) || (cur.age != model_age) ||
					($signed(it.depth) >= $signed(cur.depth));
				if (replace) begin
					fresh.key   = it.key;
					fresh.score = it.score;
					fresh.depth = it.depth;
					fresh.bound = it.bound;
					fresh.age   = model_age;
					fresh.move  = it.move;
					// track occupancy by the emptiness of old and new keys
					if (cur.key == '0 && it.key != '0)
						model_fill++;
					else if (cur.key != '0 && it.key == '0)
						model_fill--;
					table_mem[idx]   = fresh;
					table_valid[idx] = 1'b1;
					r.written        = 1'b1;
				end
			end
			CMD_PROBE: begin
				if (cur.key == it.key) begin
					r.hit   = 1'b1;
					r.score = cur.score;
					r.depth = cur.depth;
					r.bound = cur.bound;
					r.age   = cur.age;
					r.move  = cur.move;
				end
			end
			CMD_AGE: model_age = model_age + AGE_W'(1);
			CMD_CLEAR: begin
				foreach (table_valid[i])
					table_valid[i] = 1'b0;
				model_fill = 0;
			end
		endcase
		r.filled     = model_fill[FILL_W-1:0];
		r.search_age = model_age;
		return r;
	endfunction

	function automatic table_item_t make_item(input cmd_t cmd, input logic [KEY_W-1:0] key,
			input logic [SCORE_W-1:0] score, input logic [DEPTH_W-1:0] depth,
			input logic [BOUND_W-1:0] bound, input logic [MOVE_W-1:0] move);
		table_item_t it;
		it.cmd   = cmd;
		it.key   = key;
		it.score = score;
		it.depth = depth;
		it.bound = bound;
		it.move  = move;
		return it;
	endfunction

	// Mostly hot entries with a few high parts, so that keys collide and hit
	function automatic logic [KEY_W-1:0] random_key();
		logic [KEY_W-1:0]            k;
		logic [INDEX_BITS-1:0]       slot;
		logic [KEY_W-INDEX_BITS-1:0] high;
		int unsigned                 pick;
		pick = $urandom_range(99);
		if (pick < 45 && recent_keys.size() > 0) begin
			k = recent_keys[$urandom_range(recent_keys.size() - 1)];
		end else if (pick < 85) begin
			slot = INDEX_BITS'($urandom_range(7) * 521);
			high = HIGH_W'($urandom_range(5));
			high = high * HIGH_SPREAD;
			k    = {high, slot};
		end else if (pick < 95) begin
			k = {$urandom(), $urandom()};
		end else begin
			k = '0;
		end
		return k;
	endfunction

	function automatic table_item_t random_item();
		table_item_t it;
		int unsigned pick;
		pick = $urandom_range(999);
		if (pick < 12)
			it.cmd = CMD_CLEAR;
		else if (pick < 65)
			it.cmd = CMD_AGE;
		else if (pick < 560)
			it.cmd = CMD_STORE;
		else
			it.cmd = CMD_PROBE;
		it.key   = random_key();
		it.score = $urandom();
		// small depths make the depth comparison close; some take the full range
		if ($urandom_range(3) == 0)
			it.depth = DEPTH_W'($urandom());
		else
			it.depth = DEPTH_W'($urandom_range(16)) - 16'd8;
		it.bound = BOUND_W'($urandom());
		it.move  = $urandom();
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR at result %0d: %s", results_seen, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
	endtask

	// Drive one item at the falling edge, hold it until accepted, then predict
	task automatic send_item(input table_item_t it);
		res_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = it.cmd;
		s_tdata  = {it.move, it.bound, it.depth, it.score, it.key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted       = apply_table_item(it);
		pending_results = {pending_results, predicted};
		items_sent++;
		if (it.cmd == CMD_CLEAR)
			clears_sent++;
		else if (it.cmd == CMD_AGE)
			ages_sent++;
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Output stream back-pressure
	always @(negedge clk)
		m_tready = ($urandom_range(99) >= recv_idle_pct);

	// Check each accepted result and watch for a hung stream
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with no item waiting for one");
				end else begin
					want = pending_results.pop_front();
					if (want.hit)
						hits_seen++;
					if (want.written)
						writes_seen++;
					check_field("hit", 64'(m_tuser[0]), 64'(want.hit));
					check_field("written", 64'(m_tuser[1]), 64'(want.written));
					check_field("found_score", 64'(m_tdata[31:0]), 64'(want.score));
					check_field("found_depth", 64'(m_tdata[47:32]), 64'(want.depth));
					check_field("found_bound", 64'(m_tdata[55:48]), 64'(want.bound));
					check_field("found_age", 64'(m_tdata[63:56]), 64'(want.age));
					check_field("found_move", 64'(m_tdata[95:64]), 64'(want.move));
					check_field("filled_count", 64'(m_tdata[108:96]), 64'(want.filled));
					check_field("search_age", 64'(m_tdata[116:109]),
						64'(want.search_age));
					check_field("padding", 64'(m_tdata[119:117]), '0);
				end
			end
			// a clear sweep stalls both streams while it runs; the limit lies above its length
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("ERROR: no item moved for %0d cycles", stall_cycles);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	// Known empty table, probes of empty entries, a store at the field extremes
	task automatic test_basic_ops();
		send_item(make_item(CMD_CLEAR, '0, '0, '0, '0, '0));
		send_item(make_item(CMD_PROBE, '0, $urandom(), DEPTH_W'($urandom()),
			BOUND_W'($urandom()), $urandom()));
		send_item(make_item(CMD_PROBE, '1, '0, '0, '0, '0));
		send_item(make_item(CMD_STORE, '1, 32'h7FFF_FFFF, 16'h7FFF, 8'hFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_PROBE, '1, '0, '0, '0, '0));
	endtask

	// Collisions on one entry: depth, same key and stale age all decide
	task automatic test_replacement();
		logic [KEY_W-1:0] low_key;
		low_key = 64'h0000_0000_0000_0FFF;
		send_item(make_item(CMD_STORE, low_key, 32'h8000_0000, 16'h8000, 8'h00, 32'h0));
		send_item(make_item(CMD_STORE, low_key, 32'h8000_0000, 16'h7FFF, 8'h00, 32'h0));
		send_item(make_item(CMD_STORE, '1, 32'h1, 16'h8000, 8'h01, 32'h1));
		send_item(make_item(CMD_STORE, low_key, 32'h8000_0000, 16'h8000, 8'h00, 32'h0));
		send_item(make_item(CMD_PROBE, low_key, '1, '1, '1, '1));
		send_item(make_item(CMD_AGE, '0, '0, '0, '0, '0));
		send_item(make_item(CMD_STORE, '1, 32'h5A5A_A5A5, 16'h8000, 8'h3C, 32'hC3C3_3C3C));
		send_item(make_item(CMD_PROBE, '1, '0, '0, '0, '0));
	endtask

	// Key zero counts as empty both when stored over and when storing
	task automatic test_zero_key();
		send_item(make_item(CMD_STORE, '0, 32'd5, 16'd3, 8'd2, 32'd9));
		send_item(make_item(CMD_PROBE, '0, '0, '0, '0, '0));
		send_item(make_item(CMD_STORE, 64'h1000, 32'd6, 16'd3, 8'd1, 32'd7));
		send_item(make_item(CMD_STORE, '0, 32'd8, 16'h8000, 8'd0, 32'd0));
		send_item(make_item(CMD_STORE, '0, 32'd8, 16'd3, 8'd0, 32'd0));
	endtask

	// Clear empties the table and keeps the search age
	task automatic test_clear_keeps_age();
		send_item(make_item(CMD_CLEAR, '1, '1, '1, '1, '1));
		send_item(make_item(CMD_PROBE, '1, '0, '0, '0, '0));
		send_item(make_item(CMD_PROBE, '0, '0, '0, '0, '0));
	endtask

	// Step the age round to zero, then store and read back at the wrapped age
	task automatic test_age_wrap();
		int unsigned steps;
		steps = 256 - model_age;
		repeat (steps)
			send_item(make_item(CMD_AGE, {$urandom(), $urandom()}, $urandom(),
				DEPTH_W'($urandom()), BOUND_W'($urandom()), $urandom()));
		send_item(make_item(CMD_STORE, 64'h0123_4567_89AB_C001, 32'd11, 16'd5, 8'd1, 32'd42));
		send_item(make_item(CMD_PROBE, 64'h0123_4567_89AB_C001, '0, '0, '0, '0));
	endtask

	task automatic test_random_traffic(input int unsigned count);
		table_item_t it;
		for (int unsigned i = 0; i < count; i++) begin
			it = random_item();
			// remember stored keys so that later probes and stores hit them
			if (it.cmd == CMD_STORE) begin
				recent_keys = {recent_keys, it.key};
				if (recent_keys.size() > RECENT_KEEP)
					void'(recent_keys.pop_front());
			end
			send_item(it);
		end
	endtask

	task automatic finish_run();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		$display("Covered %0d items: %0d probe hits, %0d stores written, %0d clears,",
			items_sent, hits_seen, writes_seen, clears_sent);
		$display("%0d search age steps with wrap; %0d results checked, %0d mismatches",
			ages_sent, results_seen, error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	endtask

	initial begin
		// hold reset, then release it on a falling edge
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idling(17, 56);
		test_basic_ops();
		test_replacement();
		test_zero_key();
		test_clear_keeps_age();
		test_age_wrap();
		test_random_traffic(RANDOM_ITEMS);

		set_idling(56, 17);
		test_random_traffic(RANDOM_ITEMS);

		set_idling(0, 0);
		test_random_traffic(RANDOM_ITEMS);

		finish_run();
	end

endmodule
